// ===== design/tsdfpi_pkg.sv =====
`timescale 1ns / 1ps

package tsdfpi_pkg;

   localparam int DEFAULT_VOLUME_SIDE = 64;

   // truncation radius in 1/256 voxel, kept clamped to its legal range
   localparam logic [11:0] TRUNC_RESET = 12'd1024;
   localparam logic [11:0] TRUNC_MIN   = 12'd16;
   localparam logic [11:0] TRUNC_MAX   = 12'd2048;

   // full sample weight, 1.0 in units of 1/4096
   localparam logic [12:0] WEIGHT_ONE = 13'd4096;
   localparam logic [15:0] WEIGHT_SAT = 16'hFFFF;

   typedef struct packed {
      logic               valid;
      logic signed [12:0] sdf;
      logic [15:0]        weight;
      logic signed [15:0] norm_x;
      logic signed [15:0] norm_y;
      logic signed [15:0] norm_z;
      logic [7:0]         red;
      logic [7:0]         green;
      logic [7:0]         blue;
   } voxel_word_type;

endpackage

// ===== design/tsdf_point_integration_core.sv =====
`timescale 1ns / 1ps

// TSDF point integration over a dense voxel volume of VOLUME_SIDE^3 voxels.
// Command port: an item transfers on a clock edge with start high and busy low.
// req_op 0 fuses one oriented colored point into every voxel whose center lies
// within the truncation radius; req_op 1 reads the voxel at req_voxel_index.
// Each item gives exactly one result, shown for one cycle with rsp_strobe high;
// the receiver takes it in that cycle and cannot stall it.
// csr_write_en/csr_write_data set the truncation radius (clamped to 16..2048).
// Structure: one voxel store (single-port read, registered data) is visited one
// voxel at a time by a sequencer with a bit-serial square root and a shared
// restoring divider. A read item issues the store read, then returns the data.
// An integrate item sets up the box around the point; per voxel it forms the
// offsets, products and sums and tests the radius. A voxel outside is skipped;
// one inside gets the square root and the weight division and is written if
// empty, else blended by seven averages if the summed weight is nonzero.
// After reset the voxel store is cleared one entry per cycle; busy stays high
// meanwhile, while radius writes are taken at any time.
module tsdf_point_integration_core
   import tsdfpi_pkg::*;
#(
   parameter int VOLUME_SIDE = DEFAULT_VOLUME_SIDE
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   output logic               busy,
   input  logic               req_op,
   input  logic [13:0]        req_pos_x,
   input  logic [13:0]        req_pos_y,
   input  logic [13:0]        req_pos_z,
   input  logic signed [15:0] req_norm_x,
   input  logic signed [15:0] req_norm_y,
   input  logic signed [15:0] req_norm_z,
   input  logic [7:0]         req_red,
   input  logic [7:0]         req_green,
   input  logic [7:0]         req_blue,
   input  logic [17:0]        req_voxel_index,
   input  logic               csr_write_en,
   input  logic [11:0]        csr_write_data,
   output logic               rsp_strobe,
   output logic               rsp_voxel_valid,
   output logic signed [12:0] rsp_distance,
   output logic [15:0]        rsp_weight,
   output logic signed [15:0] rsp_avg_norm_x,
   output logic signed [15:0] rsp_avg_norm_y,
   output logic signed [15:0] rsp_avg_norm_z,
   output logic [7:0]         rsp_avg_red,
   output logic [7:0]         rsp_avg_green,
   output logic [7:0]         rsp_avg_blue,
   output logic [12:0]        rsp_updated_count
);

   localparam int CW     = $clog2(VOLUME_SIDE);
   localparam int NVOX   = VOLUME_SIDE * VOLUME_SIDE * VOLUME_SIDE;
   localparam int ADDR_W = $clog2(NVOX);
   localparam logic [ADDR_W-1:0] LAST_ADDR    = ADDR_W'(NVOX - 1);
   localparam logic [ADDR_W-1:0] ROW_STRIDE   = ADDR_W'(VOLUME_SIDE);
   localparam logic [ADDR_W-1:0] PLANE_STRIDE = ADDR_W'(VOLUME_SIDE * VOLUME_SIDE);
   localparam logic [7:0]        COORD_MAX    = 8'(VOLUME_SIDE - 1);
   localparam logic [31:0]       NVOX_W       = 32'(NVOX);
   localparam logic [4:0]        SQRT_LAST    = 5'd23;
   localparam logic [4:0]        DIV_LAST     = 5'd16;
   localparam logic [2:0]        AVG_LAST     = 3'd6;

   typedef enum logic [4:0] {
      ST_CLEAR, ST_IDLE, ST_RD_ISSUE, ST_RD_DATA, ST_SETUP,
      ST_VOX_D, ST_VOX_P, ST_VOX_S, ST_VOX_C, ST_SQRT, ST_WDIV,
      ST_CHK, ST_AMUL, ST_ALOAD, ST_ADIV, ST_WRITE
   } state_type;

   state_type state_ff;

   // voxel store
   voxel_word_type voxel_mem [NVOX];
   voxel_word_type mem_rdata_ff;
   voxel_word_type mem_wdata;
   logic              mem_we, mem_re;
   logic [ADDR_W-1:0] mem_waddr, mem_raddr;

   logic [ADDR_W-1:0] clr_addr_ff;
   logic [11:0]       trunc_ff;
   logic [22:0]       tsq_ff;

   logic [17:0]        idx_ff;
   logic               idx_ok_ff;
   logic [13:0]        pos_ff [3];
   logic signed [15:0] norm_ff [3];
   logic [7:0]         col_ff [3];
   logic [CW-1:0]      lo_ff [3];
   logic [CW-1:0]      hi_ff [3];
   logic [CW-1:0]      crd_ff [3];
   logic [CW-1:0]      crd_next [3];
   logic               last_vox;
   logic [ADDR_W-1:0]  vox_addr;

   logic signed [12:0] d_ff [3];
   logic [25:0]        sq_ff [3];
   logic signed [28:0] dp_ff [3];
   logic [23:0]        dsq_ff;
   logic signed [30:0] dot_ff;
   logic signed [12:0] s_ff;
   logic [12:0]        count_ff;

   // axis ranges
   logic signed [15:0] ax_a [3];
   logic signed [15:0] ax_b [3];
   logic signed [15:0] ax_up [3];
   logic [7:0]         ax_lo [3];
   logic [7:0]         ax_hi [3];
   logic [2:0]         ax_empty;
   logic signed [17:0] ctr_d [3];

   // clamped distance sample
   logic signed [30:0] s_sh;
   logic signed [30:0] t_s;
   logic signed [12:0] s_in;

   // square root
   logic [23:0] rad_ff;
   logic [25:0] rem_ff;
   logic [23:0] root_ff;
   logic [27:0] sq_trial, sq_sub;
   logic        sq_ge;
   logic [25:0] rem_in;
   logic [23:0] root_in;
   logic [4:0]  step_ff;

   // shared divider
   logic [17:0] div_rem_ff;
   logic [16:0] div_low_ff;
   logic [17:0] div_den_ff;
   logic [16:0] div_quo_ff;
   logic        div_neg_ff;
   logic [18:0] div_shift;
   logic        div_ge;
   logic [17:0] div_rem_in;
   logic [16:0] div_quo_in;
   logic [17:0] div_res;
   logic [34:0] w_dvd;

   // weighted average
   logic [12:0]        w_ff;
   logic [16:0]        tot_ff;
   logic [16:0]        tot_in;
   logic [2:0]         k_ff;
   logic signed [15:0] old_val, new_val;
   logic signed [32:0] po_ff;
   logic signed [29:0] pn_ff;
   logic signed [35:0] a_num, a_n;
   logic [34:0]        a_dvd;
   logic signed [15:0] avg_ff [7];

   logic               rsp_strobe_ff, rsp_voxel_valid_ff;
   logic signed [12:0] rsp_distance_ff;
   logic [15:0]        rsp_weight_ff;
   logic signed [15:0] rsp_norm_ff [3];
   logic [7:0]         rsp_col_ff [3];
   logic [12:0]        rsp_count_ff;

   assign busy              = (state_ff != ST_IDLE);
   assign rsp_strobe        = rsp_strobe_ff;
   assign rsp_voxel_valid   = rsp_voxel_valid_ff;
   assign rsp_distance      = rsp_distance_ff;
   assign rsp_weight        = rsp_weight_ff;
   assign rsp_avg_norm_x    = rsp_norm_ff[0];
   assign rsp_avg_norm_y    = rsp_norm_ff[1];
   assign rsp_avg_norm_z    = rsp_norm_ff[2];
   assign rsp_avg_red       = rsp_col_ff[0];
   assign rsp_avg_green     = rsp_col_ff[1];
   assign rsp_avg_blue      = rsp_col_ff[2];
   assign rsp_updated_count = rsp_count_ff;

   assign vox_addr = ADDR_W'(crd_ff[0]) + ADDR_W'(crd_ff[1]) * ROW_STRIDE
                   + ADDR_W'(crd_ff[2]) * PLANE_STRIDE;

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         ax_a[i]  = signed'({2'b00, pos_ff[i]}) - signed'({4'b0000, trunc_ff}) - 16'sd128;
         ax_b[i]  = signed'({2'b00, pos_ff[i]}) + signed'({4'b0000, trunc_ff}) - 16'sd128;
         ax_up[i] = ax_a[i] + 16'sd255;
         ax_lo[i] = (ax_a[i] <= 16'sd0) ? 8'd0 : ax_up[i][15:8];
         ax_hi[i] = (ax_b[i][15:8] > COORD_MAX) ? COORD_MAX : ax_b[i][15:8];
         ax_empty[i] = ax_b[i][15] | (ax_lo[i] > ax_hi[i]);
         ctr_d[i] = signed'(18'({crd_ff[i], 8'h80})) - signed'(18'(pos_ff[i]));
      end
   end

   // walk x fastest, then y, then z
   always_comb begin
      for (int i = 0; i < 3; i++) crd_next[i] = crd_ff[i];
      last_vox = 1'b0;
      if (crd_ff[0] != hi_ff[0]) begin
         crd_next[0] = crd_ff[0] + CW'(1);
      end else begin
         crd_next[0] = lo_ff[0];
         if (crd_ff[1] != hi_ff[1]) begin
            crd_next[1] = crd_ff[1] + CW'(1);
         end else begin
            crd_next[1] = lo_ff[1];
            if (crd_ff[2] != hi_ff[2]) crd_next[2] = crd_ff[2] + CW'(1);
            else last_vox = 1'b1;
         end
      end
   end

   always_comb begin
      s_sh = dot_ff >>> 14;
      t_s  = signed'(31'(trunc_ff));
      if (s_sh > t_s) s_in = 13'(t_s);
      else if (s_sh < -t_s) s_in = 13'(-t_s);
      else s_in = 13'(s_sh);
   end

   always_comb begin
      sq_trial = {rem_ff, rad_ff[23:22]};
      sq_sub   = {2'b00, root_ff, 2'b01};
      sq_ge    = (sq_trial >= sq_sub);
      rem_in   = sq_ge ? 26'(sq_trial - sq_sub) : 26'(sq_trial);
      root_in  = {root_ff[22:0], sq_ge};
      w_dvd    = 35'(root_in);
   end

   always_comb begin
      div_shift  = {div_rem_ff, div_low_ff[16]};
      div_ge     = (div_shift >= {1'b0, div_den_ff});
      div_rem_in = div_ge ? 18'(div_shift - {1'b0, div_den_ff}) : div_shift[17:0];
      div_quo_in = {div_quo_ff[15:0], div_ge};
      // floor of a negative quotient: ~(~N / D)
      div_res    = div_neg_ff ? ~{1'b0, div_quo_in} : {1'b0, div_quo_in};
   end

   always_comb begin
      tot_in = 17'(mem_rdata_ff.weight) + 17'(w_ff);
      unique case (k_ff)
         3'd0: begin
            old_val = 16'(mem_rdata_ff.sdf);
            new_val = 16'(s_ff);
         end
         3'd1: begin
            old_val = mem_rdata_ff.norm_x;
            new_val = norm_ff[0];
         end
         3'd2: begin
            old_val = mem_rdata_ff.norm_y;
            new_val = norm_ff[1];
         end
         3'd3: begin
            old_val = mem_rdata_ff.norm_z;
            new_val = norm_ff[2];
         end
         3'd4: begin
            old_val = signed'({8'd0, mem_rdata_ff.red});
            new_val = signed'({8'd0, col_ff[0]});
         end
         3'd5: begin
            old_val = signed'({8'd0, mem_rdata_ff.green});
            new_val = signed'({8'd0, col_ff[1]});
         end
         3'd6: begin
            old_val = signed'({8'd0, mem_rdata_ff.blue});
            new_val = signed'({8'd0, col_ff[2]});
         end
         default: begin
            old_val = '0;
            new_val = '0;
         end
      endcase
      // round(num / tot) with ties up = floor((2*num + tot) / (2*tot))
      a_num = 36'(po_ff) + 36'(pn_ff);
      a_n   = (a_num <<< 1) + signed'(36'(tot_ff));
      a_dvd = a_n[35] ? 35'(~a_n) : 35'(a_n);
   end

   always_comb begin
      mem_we    = 1'b0;
      mem_re    = 1'b0;
      mem_waddr = vox_addr;
      mem_raddr = vox_addr;
      mem_wdata = '0;
      unique case (state_ff)
         ST_CLEAR: begin
            mem_we    = 1'b1;
            mem_waddr = clr_addr_ff;
         end
         ST_RD_ISSUE: begin
            mem_re    = idx_ok_ff;
            mem_raddr = ADDR_W'(idx_ff);
         end
         ST_VOX_D: mem_re = 1'b1;
         ST_CHK: begin
            mem_we = !mem_rdata_ff.valid;
            mem_wdata = '{valid: 1'b1, sdf: s_ff, weight: {3'b000, w_ff},
                          norm_x: norm_ff[0], norm_y: norm_ff[1], norm_z: norm_ff[2],
                          red: col_ff[0], green: col_ff[1], blue: col_ff[2]};
         end
         ST_WRITE: begin
            mem_we = 1'b1;
            mem_wdata = '{valid: 1'b1, sdf: avg_ff[0][12:0],
                          weight: tot_ff[16] ? WEIGHT_SAT : tot_ff[15:0],
                          norm_x: avg_ff[1], norm_y: avg_ff[2], norm_z: avg_ff[3],
                          red: avg_ff[4][7:0], green: avg_ff[5][7:0],
                          blue: avg_ff[6][7:0]};
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (mem_we) voxel_mem[mem_waddr] <= mem_wdata;
      if (mem_re) mem_rdata_ff <= voxel_mem[mem_raddr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         trunc_ff <= TRUNC_RESET;
      end else if (csr_write_en) begin
         if (csr_write_data < TRUNC_MIN) trunc_ff <= TRUNC_MIN;
         else if (csr_write_data > TRUNC_MAX) trunc_ff <= TRUNC_MAX;
         else trunc_ff <= csr_write_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_CLEAR;
         clr_addr_ff   <= '0;
         rsp_strobe_ff <= 1'b0;
      end else begin
         rsp_strobe_ff <= 1'b0;
         unique case (state_ff)
            ST_CLEAR: begin
               clr_addr_ff <= clr_addr_ff + ADDR_W'(1);
               if (clr_addr_ff == LAST_ADDR) state_ff <= ST_IDLE;
            end
            ST_IDLE: begin
               if (start) begin
                  pos_ff[0]  <= req_pos_x;
                  pos_ff[1]  <= req_pos_y;
                  pos_ff[2]  <= req_pos_z;
                  norm_ff[0] <= req_norm_x;
                  norm_ff[1] <= req_norm_y;
                  norm_ff[2] <= req_norm_z;
                  col_ff[0]  <= req_red;
                  col_ff[1]  <= req_green;
                  col_ff[2]  <= req_blue;
                  idx_ff     <= req_voxel_index;
                  idx_ok_ff  <= ({14'd0, req_voxel_index} < NVOX_W);
                  count_ff   <= '0;
                  state_ff   <= req_op ? ST_RD_ISSUE : ST_SETUP;
               end
            end
            ST_RD_ISSUE: state_ff <= ST_RD_DATA;
            ST_RD_DATA: begin
               rsp_strobe_ff <= 1'b1;
               rsp_count_ff  <= '0;
               if (idx_ok_ff && mem_rdata_ff.valid) begin
                  rsp_voxel_valid_ff <= 1'b1;
                  rsp_distance_ff    <= mem_rdata_ff.sdf;
                  rsp_weight_ff      <= mem_rdata_ff.weight;
                  rsp_norm_ff[0]     <= mem_rdata_ff.norm_x;
                  rsp_norm_ff[1]     <= mem_rdata_ff.norm_y;
                  rsp_norm_ff[2]     <= mem_rdata_ff.norm_z;
                  rsp_col_ff[0]      <= mem_rdata_ff.red;
                  rsp_col_ff[1]      <= mem_rdata_ff.green;
                  rsp_col_ff[2]      <= mem_rdata_ff.blue;
               end else begin
                  rsp_voxel_valid_ff <= 1'b0;
                  rsp_distance_ff    <= '0;
                  rsp_weight_ff      <= '0;
                  for (int i = 0; i < 3; i++) begin
                     rsp_norm_ff[i] <= '0;
                     rsp_col_ff[i]  <= '0;
                  end
               end
               state_ff <= ST_IDLE;
            end
            ST_SETUP: begin
               tsq_ff <= 23'(trunc_ff * trunc_ff);
               for (int i = 0; i < 3; i++) begin
                  lo_ff[i]  <= ax_lo[i][CW-1:0];
                  hi_ff[i]  <= ax_hi[i][CW-1:0];
                  crd_ff[i] <= ax_lo[i][CW-1:0];
               end
               if (ax_empty != 3'b000) begin
                  rsp_strobe_ff      <= 1'b1;
                  rsp_voxel_valid_ff <= 1'b0;
                  rsp_distance_ff    <= '0;
                  rsp_weight_ff      <= '0;
                  for (int i = 0; i < 3; i++) begin
                     rsp_norm_ff[i] <= '0;
                     rsp_col_ff[i]  <= '0;
                  end
                  rsp_count_ff <= '0;
                  state_ff     <= ST_IDLE;
               end else begin
                  state_ff <= ST_VOX_D;
               end
            end
            ST_VOX_D: begin
               for (int i = 0; i < 3; i++) d_ff[i] <= ctr_d[i][12:0];
               state_ff <= ST_VOX_P;
            end
            ST_VOX_P: begin
               for (int i = 0; i < 3; i++) begin
                  sq_ff[i] <= 26'(d_ff[i] * d_ff[i]);
                  dp_ff[i] <= d_ff[i] * norm_ff[i];
               end
               state_ff <= ST_VOX_S;
            end
            ST_VOX_S: begin
               dsq_ff <= 24'(sq_ff[0] + sq_ff[1] + sq_ff[2]);
               dot_ff <= 31'(dp_ff[0]) + 31'(dp_ff[1]) + 31'(dp_ff[2]) + 31'sd8192;
               state_ff <= ST_VOX_C;
            end
            ST_VOX_C: begin
               if (dsq_ff > 24'(tsq_ff)) begin
                  // outside the radius: skip, not counted
                  if (last_vox) begin
                     rsp_strobe_ff      <= 1'b1;
                     rsp_voxel_valid_ff <= 1'b0;
                     rsp_distance_ff    <= '0;
                     rsp_weight_ff      <= '0;
                     for (int i = 0; i < 3; i++) begin
                        rsp_norm_ff[i] <= '0;
                        rsp_col_ff[i]  <= '0;
                     end
                     rsp_count_ff <= count_ff;
                     state_ff     <= ST_IDLE;
                  end else begin
                     for (int i = 0; i < 3; i++) crd_ff[i] <= crd_next[i];
                     state_ff <= ST_VOX_D;
                  end
               end else begin
                  s_ff     <= s_in;
                  count_ff <= count_ff + 13'd1;
                  rad_ff   <= dsq_ff;
                  rem_ff   <= '0;
                  root_ff  <= '0;
                  step_ff  <= '0;
                  state_ff <= ST_SQRT;
               end
            end
            ST_SQRT: begin
               // two radicand bits per step; the low 24 bits are zero
               rad_ff  <= {rad_ff[21:0], 2'b00};
               rem_ff  <= rem_in;
               root_ff <= root_in;
               if (step_ff == SQRT_LAST) begin
                  div_rem_ff <= w_dvd[34:17];
                  div_low_ff <= w_dvd[16:0];
                  div_den_ff <= 18'(trunc_ff);
                  div_quo_ff <= '0;
                  div_neg_ff <= 1'b0;
                  step_ff    <= '0;
                  state_ff   <= ST_WDIV;
               end else begin
                  step_ff <= step_ff + 5'd1;
               end
            end
            ST_WDIV: begin
               div_rem_ff <= div_rem_in;
               div_low_ff <= {div_low_ff[15:0], 1'b0};
               div_quo_ff <= div_quo_in;
               step_ff    <= step_ff + 5'd1;
               if (step_ff == DIV_LAST) begin
                  if (div_quo_in > 17'(WEIGHT_ONE)) w_ff <= '0;
                  else w_ff <= 13'(17'(WEIGHT_ONE) - div_quo_in);
                  state_ff <= ST_CHK;
               end
            end
            ST_CHK: begin
               if (mem_rdata_ff.valid && (tot_in != 17'd0)) begin
                  tot_ff   <= tot_in;
                  k_ff     <= '0;
                  state_ff <= ST_AMUL;
               end else if (last_vox) begin
                  rsp_strobe_ff      <= 1'b1;
                  rsp_voxel_valid_ff <= 1'b0;
                  rsp_distance_ff    <= '0;
                  rsp_weight_ff      <= '0;
                  for (int i = 0; i < 3; i++) begin
                     rsp_norm_ff[i] <= '0;
                     rsp_col_ff[i]  <= '0;
                  end
                  rsp_count_ff <= count_ff;
                  state_ff     <= ST_IDLE;
               end else begin
                  for (int i = 0; i < 3; i++) crd_ff[i] <= crd_next[i];
                  state_ff <= ST_VOX_D;
               end
            end
            ST_AMUL: begin
               po_ff    <= old_val * signed'({1'b0, mem_rdata_ff.weight});
               pn_ff    <= new_val * signed'({1'b0, w_ff});
               state_ff <= ST_ALOAD;
            end
            ST_ALOAD: begin
               div_rem_ff <= a_dvd[34:17];
               div_low_ff <= a_dvd[16:0];
               div_den_ff <= {tot_ff, 1'b0};
               div_quo_ff <= '0;
               div_neg_ff <= a_n[35];
               step_ff    <= '0;
               state_ff   <= ST_ADIV;
            end
            ST_ADIV: begin
               div_rem_ff <= div_rem_in;
               div_low_ff <= {div_low_ff[15:0], 1'b0};
               div_quo_ff <= div_quo_in;
               step_ff    <= step_ff + 5'd1;
               if (step_ff == DIV_LAST) begin
                  avg_ff[k_ff] <= signed'(div_res[15:0]);
                  k_ff         <= k_ff + 3'd1;
                  state_ff     <= (k_ff == AVG_LAST) ? ST_WRITE : ST_AMUL;
               end
            end
            ST_WRITE: begin
               if (last_vox) begin
                  rsp_strobe_ff      <= 1'b1;
                  rsp_voxel_valid_ff <= 1'b0;
                  rsp_distance_ff    <= '0;
                  rsp_weight_ff      <= '0;
                  for (int i = 0; i < 3; i++) begin
                     rsp_norm_ff[i] <= '0;
                     rsp_col_ff[i]  <= '0;
                  end
                  rsp_count_ff <= count_ff;
                  state_ff     <= ST_IDLE;
               end else begin
                  for (int i = 0; i < 3; i++) crd_ff[i] <= crd_next[i];
                  state_ff <= ST_VOX_D;
               end
            end
            default: state_ff <= ST_IDLE;
         endcase
      end
   end

   a_strobe_after_work: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> $past(busy))
      else $error("result strobe without an item in progress");

   a_accept_goes_busy: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> busy)
      else $error("accepted item did not raise busy");

   a_trunc_range: assert property (@(posedge clock) disable iff (reset)
      (trunc_ff >= TRUNC_MIN) && (trunc_ff <= TRUNC_MAX))
      else $error("truncation radius out of range");

   a_write_after_blend: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_WRITE) |-> ($past(state_ff) == ST_ADIV) && ($past(k_ff) == AVG_LAST))
      else $error("voxel write-back before all averages were done");

endmodule

// ===== test/tb_tsdf_point_integration_core.sv =====
`timescale 1ns / 1ps

module tb_tsdf_point_integration_core
   import tsdfpi_pkg::*;
();

   localparam int SIDE = DEFAULT_VOLUME_SIDE;
   localparam int NVOX = SIDE * SIDE * SIDE;
   localparam bit OP_FUSE = 1'b0;
   localparam bit OP_READ = 1'b1;

   typedef struct {
      bit               op;
      bit [13:0]        px, py, pz;
      bit signed [15:0] nx, ny, nz;
      bit [7:0]         r, g, b;
      bit [17:0]        idx;
   } point_cmd_type;

   typedef struct {
      bit               valid;
      bit signed [12:0] sdf;
      bit [15:0]        weight;
      bit signed [15:0] nx, ny, nz;
      bit [7:0]         r, g, b;
      bit [12:0]        count;
   } voxel_rsp_type;

   logic clock = 0;
   logic reset = 1;
   logic start = 0;
   logic busy;
   logic csr_write_en = 0;
   logic [11:0] csr_write_data = 0;
   logic rsp_strobe, rsp_voxel_valid;
   logic signed [12:0] rsp_distance;
   logic [15:0] rsp_weight;
   logic signed [15:0] rsp_avg_norm_x, rsp_avg_norm_y, rsp_avg_norm_z;
   logic [7:0] rsp_avg_red, rsp_avg_green, rsp_avg_blue;
   logic [12:0] rsp_updated_count;

   point_cmd_type cur = '{default: 0};
   point_cmd_type pending[$];
   voxel_rsp_type expected_rsp[$];
   logic took = 0;
   int errors = 0;
   int sent = 0;

   // shadow copy of the voxel store and the radius register
   bit               vox_valid[NVOX];
   bit signed [12:0] vox_dist[NVOX];
   bit [15:0]        vox_weight[NVOX];
   bit signed [15:0] vox_norm[NVOX][3];
   bit [7:0]         vox_color[NVOX][3];
   int               radius = 1024;

   always begin
      #4 clock = 1;
      #4 clock = 0;
   end

   tsdf_point_integration_core dut (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .req_op(cur.op), .req_pos_x(cur.px), .req_pos_y(cur.py), .req_pos_z(cur.pz),
      .req_norm_x(cur.nx), .req_norm_y(cur.ny), .req_norm_z(cur.nz),
      .req_red(cur.r), .req_green(cur.g), .req_blue(cur.b),
      .req_voxel_index(cur.idx),
      .csr_write_en(csr_write_en), .csr_write_data(csr_write_data),
      .rsp_strobe(rsp_strobe), .rsp_voxel_valid(rsp_voxel_valid),
      .rsp_distance(rsp_distance), .rsp_weight(rsp_weight),
      .rsp_avg_norm_x(rsp_avg_norm_x), .rsp_avg_norm_y(rsp_avg_norm_y),
      .rsp_avg_norm_z(rsp_avg_norm_z), .rsp_avg_red(rsp_avg_red),
      .rsp_avg_green(rsp_avg_green), .rsp_avg_blue(rsp_avg_blue),
      .rsp_updated_count(rsp_updated_count)
   );

   function automatic void add_cmd(point_cmd_type c);
      pending = {pending, c};
   endfunction

   function automatic longint unsigned int_sqrt(longint unsigned v);
      longint unsigned root = 0;
      longint unsigned bitv = 64'd1 << 62;
      while (bitv > v) bitv >>= 2;
      while (bitv != 0) begin
         if (v >= root + bitv) begin
            v -= root + bitv;
            root = (root >> 1) + bitv;
         end else
            root >>= 1;
         bitv >>= 2;
      end
      return root;
   endfunction

   function automatic longint floor_quot(longint a, longint d);
      longint q = a / d;
      if ((a % d) != 0 && a < 0) q--;
      return q;
   endfunction

   function automatic longint round_quot(longint num, longint den);
      return floor_quot(2 * num + den, 2 * den);
   endfunction

   // compute the response and update the shadow store
   function automatic voxel_rsp_type fuse_or_read(point_cmd_type c);
      voxel_rsp_type res = '{default: 0};
      longint t, p[3], n[3], col[3], lo[3], hi[3], a, bb;
      longint dx, dy, dz, dsq, w, s, wo, tot;
      int v, cnt;
      if (c.op == OP_READ) begin
         if (c.idx < NVOX && vox_valid[c.idx]) begin
            res.valid = 1;
            res.sdf = vox_dist[c.idx];
            res.weight = vox_weight[c.idx];
            res.nx = vox_norm[c.idx][0];
            res.ny = vox_norm[c.idx][1];
            res.nz = vox_norm[c.idx][2];
            res.r = vox_color[c.idx][0];
            res.g = vox_color[c.idx][1];
            res.b = vox_color[c.idx][2];
         end
         return res;
      end
      t = radius < 16 ? 16 : (radius > 2048 ? 2048 : radius);
      p[0] = c.px; p[1] = c.py; p[2] = c.pz;
      n[0] = c.nx; n[1] = c.ny; n[2] = c.nz;
      col[0] = c.r; col[1] = c.g; col[2] = c.b;
      for (int j = 0; j < 3; j++) begin
         a = p[j] - t - 128;
         bb = p[j] + t - 128;
         lo[j] = (a <= 0) ? 0 : (a + 255) / 256;
         if (bb < 0) hi[j] = -1;
         else hi[j] = (bb / 256 > SIDE - 1) ? SIDE - 1 : bb / 256;
      end
      cnt = 0;
      for (longint z = lo[2]; z <= hi[2]; z++)
         for (longint y = lo[1]; y <= hi[1]; y++)
            for (longint x = lo[0]; x <= hi[0]; x++) begin
               dx = 256 * x + 128 - p[0];
               dy = 256 * y + 128 - p[1];
               dz = 256 * z + 128 - p[2];
               dsq = dx * dx + dy * dy + dz * dz;
               if (dsq > t * t) continue;
               w = 4096 - longint'(int_sqrt(longint'(dsq) << 24)) / t;
               if (w < 0) w = 0;
               s = floor_quot(dx * n[0] + dy * n[1] + dz * n[2] + 8192, 16384);
               if (s > t) s = t;
               if (s < -t) s = -t;
               v = int'(x + y * SIDE + z * SIDE * SIDE);
               cnt++;
               if (!vox_valid[v]) begin
                  vox_valid[v] = 1;
                  vox_dist[v] = 13'(s);
                  vox_weight[v] = 16'(w);
                  for (int j = 0; j < 3; j++) begin
                     vox_norm[v][j] = 16'(n[j]);
                     vox_color[v][j] = 8'(col[j]);
                  end
                  continue;
               end
               wo = vox_weight[v];
               tot = wo + w;
               if (tot == 0) continue;
               vox_dist[v] = 13'(round_quot(longint'(vox_dist[v]) * wo + s * w, tot));
               for (int j = 0; j < 3; j++) begin
                  vox_norm[v][j] =
                     16'(round_quot(longint'(vox_norm[v][j]) * wo + n[j] * w, tot));
                  vox_color[v][j] =
                     8'(round_quot(longint'(vox_color[v][j]) * wo + col[j] * w, tot));
               end
               vox_weight[v] = 16'((tot > 65535) ? 65535 : tot);
            end
      res.count = 13'(cnt);
      return res;
   endfunction

   task automatic report_mismatch(string field, longint got, longint want);
      $display("mismatch %s: got %0d expected %0d at %0t", field, got, want, $realtime);
      errors++;
   endtask

   // driver: hold an item until it transfers, then advance
   always @(negedge clock) begin
      if (reset)
         start <= 0;
      else if (!start || took) begin
         if (pending.size() > 0 &&
             !((sent < 300 || sent > 450) && $urandom_range(99) < 33)) begin
            cur = pending.pop_front();
            sent++;
            start <= 1;
         end else
            start <= 0;
      end
   end

   // monitor: predict on each transfer, check each strobed result
   always @(posedge clock) begin
      voxel_rsp_type want;
      if (reset)
         took <= 0;
      else begin
         if (csr_write_en) radius = csr_write_data;
         took <= start && !busy;
         if (start && !busy) expected_rsp = {expected_rsp, fuse_or_read(cur)};
         if (rsp_strobe) begin
            if (expected_rsp.size() == 0) begin
               report_mismatch("unexpected rsp_strobe", 1, 0);
            end else begin
               want = expected_rsp.pop_front();
               if (rsp_voxel_valid !== want.valid)
                  report_mismatch("voxel_valid", rsp_voxel_valid, want.valid);
               if (rsp_distance !== want.sdf)
                  report_mismatch("distance", rsp_distance, want.sdf);
               if (rsp_weight !== want.weight)
                  report_mismatch("weight", rsp_weight, want.weight);
               if (rsp_avg_norm_x !== want.nx)
                  report_mismatch("avg_norm_x", rsp_avg_norm_x, want.nx);
               if (rsp_avg_norm_y !== want.ny)
                  report_mismatch("avg_norm_y", rsp_avg_norm_y, want.ny);
               if (rsp_avg_norm_z !== want.nz)
                  report_mismatch("avg_norm_z", rsp_avg_norm_z, want.nz);
               if (rsp_avg_red !== want.r)
                  report_mismatch("avg_red", rsp_avg_red, want.r);
               if (rsp_avg_green !== want.g)
                  report_mismatch("avg_green", rsp_avg_green, want.g);
               if (rsp_avg_blue !== want.b)
                  report_mismatch("avg_blue", rsp_avg_blue, want.b);
               if (rsp_updated_count !== want.count)
                  report_mismatch("updated_count", rsp_updated_count, want.count);
            end
         end
      end
   end

   function automatic point_cmd_type fuse_cmd(int x, int y, int z, int nx, int ny, int nz,
                                              int r, int g, int b);
      point_cmd_type c = '{default: 0};
      c.op = OP_FUSE;
      c.px = 14'(x); c.py = 14'(y); c.pz = 14'(z);
      c.nx = 16'(nx); c.ny = 16'(ny); c.nz = 16'(nz);
      c.r = 8'(r); c.g = 8'(g); c.b = 8'(b);
      c.idx = 18'($urandom);
      return c;
   endfunction

   function automatic point_cmd_type read_cmd(int idx);
      point_cmd_type c = '{default: 0};
      c.op = OP_READ;
      c.idx = 18'(idx);
      c.px = 14'($urandom); c.py = 14'($urandom); c.pz = 14'($urandom);
      return c;
   endfunction

   function automatic int rand_norm();
      if ($urandom_range(9) == 0) return $urandom_range(65535);
      return int'($urandom_range(32768)) - 16384;
   endfunction

   function automatic int jitter(int c);
      int v = c + int'($urandom_range(600)) - 300;
      return v < 0 ? 0 : (v > 16383 ? 16383 : v);
   endfunction

   task automatic set_radius(int value);
      @(negedge clock);
      csr_write_en <= 1;
      csr_write_data <= 12'(value);
      @(negedge clock);
      csr_write_en <= 0;
   endtask

   task automatic drain();
      while (pending.size() > 0 || start || expected_rsp.size() > 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   initial begin
      int cx, cy, cz, k, reps, vx;
      repeat (5) @(posedge clock);
      @(negedge clock);
      reset <= 0;

      // default radius, corner of the volume
      add_cmd(fuse_cmd(0, 0, 0, 16384, 0, 0, 255, 255, 255));
      add_cmd(read_cmd(0));
      add_cmd(read_cmd(NVOX - 1));
      drain();
      // radius below range, used as the minimum
      set_radius(0);
      add_cmd(fuse_cmd(1408, 1408, 1408, -16384, -16384, -16384, 0, 0, 0));
      add_cmd(read_cmd(5 + 5 * SIDE + 5 * SIDE * SIDE));
      add_cmd(fuse_cmd(16383, 16383, 16383, 0, 16384, 0, 1, 2, 3));
      add_cmd(read_cmd(18'h3FFFF));
      drain();
      // sample at exactly the radius has zero weight; twice gives zero total
      set_radius(256);
      add_cmd(fuse_cmd(384, 128, 128, 16'h7FFF, 16'h8000, 0, 10, 20, 30));
      add_cmd(fuse_cmd(384, 128, 128, 16'h8000, 16'h7FFF, 0, 200, 100, 50));
      add_cmd(read_cmd(0));
      add_cmd(read_cmd(1));
      drain();
      // radius above range, used as the maximum
      set_radius(4095);
      add_cmd(fuse_cmd(0, 0, 0, 0, 0, 16384, 90, 91, 92));
      add_cmd(read_cmd(0));
      drain();
      set_radius(2048);
      add_cmd(fuse_cmd(16383, 16383, 16383, 11585, 11585, 0, 255, 0, 255));
      add_cmd(read_cmd(NVOX - 1));
      drain();

      for (int ph = 0; ph < 4; ph++) begin
         set_radius(ph == 0 ? 16 : (ph == 3 ? 320 : $urandom_range(17, 319)));
         while (pending.size() < 200) begin
            k = $urandom_range(99);
            if ($urandom_range(3) == 0) begin
               cx = $urandom_range(16383); cy = $urandom_range(16383);
               cz = $urandom_range(16383);
            end else begin
               cx = $urandom_range(2047); cy = $urandom_range(2047);
               cz = $urandom_range(2047);
            end
            if (k < 60) begin
               // a few points around one spot, then reads of nearby voxels
               reps = $urandom_range(1, 4);
               for (int i = 0; i < reps; i++)
                  add_cmd(fuse_cmd(jitter(cx), jitter(cy), jitter(cz), rand_norm(),
                     rand_norm(), rand_norm(), $urandom_range(255), $urandom_range(255),
                     $urandom_range(255)));
               reps = $urandom_range(1, 3);
               for (int i = 0; i < reps; i++) begin
                  vx = (jitter(cx) >> 8) + (jitter(cy) >> 8) * SIDE
                     + (jitter(cz) >> 8) * SIDE * SIDE;
                  add_cmd(read_cmd(vx));
               end
            end else if (k < 72) begin
               // same point at a voxel center, repeated 8 to 20 times; the weight may saturate
               cx = (cx & ~255) | 128; cy = (cy & ~255) | 128; cz = (cz & ~255) | 128;
               reps = $urandom_range(8, 20);
               for (int i = 0; i < reps; i++)
                  add_cmd(fuse_cmd(cx, cy, cz, rand_norm(), rand_norm(),
                     rand_norm(), $urandom_range(255), $urandom_range(255),
                     $urandom_range(255)));
               add_cmd(read_cmd((cx >> 8) + (cy >> 8) * SIDE
                  + (cz >> 8) * SIDE * SIDE));
            end else if (k < 86)
               add_cmd(read_cmd($urandom_range(NVOX - 1)));
            else
               add_cmd(fuse_cmd($urandom_range(16383), $urandom_range(16383),
                  $urandom_range(16383), $urandom_range(65535), $urandom_range(65535),
                  $urandom_range(65535), $urandom_range(255), $urandom_range(255),
                  $urandom_range(255)));
         end
         drain();
      end

      repeat (50) @(posedge clock);
      if (errors == 0)
         $display("DONE: 0 errors");
      else
         $display("DONE: errors detected");
      $finish;
   end

   initial begin
      #400_000_000;
      $display("DONE: errors detected");
      $finish;
   end

endmodule
